// File: hw/rtl/wrs_pkg.sv
`timescale 1ns / 1ps

package wrs_pkg;

	// Default sizing of the top level
	localparam int DEF_ENTRIES     = 4;
	localparam int DEF_WEIGHT_BITS = 16;

	// Fixed field widths
	localparam int RAND_BITS      = 31;
	localparam int REG_BITS       = 16;
	localparam int COUNT_REG_BITS = 3;
	localparam int WEIGHT_REGS    = 4;
	localparam int INDEX_BITS     = 2;

	// Stream and register port widths
	localparam int TDATA_IN_BITS  = 32;
	localparam int TDATA_OUT_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;
	localparam int ADDR_BITS      = 5;
	localparam int REG_SEL_BITS   = ADDR_BITS - 2;

	// Remainder pipeline: bits of the draw retired per stage
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (RAND_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DVD_BITS   = DIV_STAGES * DIV_STEP;

	// Register map, word index
	typedef enum logic [REG_SEL_BITS-1:0] {
		REG_WEIGHT0 = 3'd0,
		REG_WEIGHT1 = 3'd1,
		REG_WEIGHT2 = 3'd2,
		REG_WEIGHT3 = 3'd3,
		REG_COUNT   = 3'd4
	} reg_idx_t;

	// Special cases decided from the table alone
	typedef struct packed {
		logic none;      // no entries in use
		logic all_zero;  // total weight is zero
	} sel_mode_t;

endpackage

// File: hw/rtl/wrs_div_stage.sv
`timescale 1ns / 1ps

module wrs_div_stage
	import wrs_pkg::*;
#(
	parameter int TOTAL_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TOTAL_BITS-1:0] in_rem,
	input  logic [DVD_BITS-1:0]   in_dvd,
	input  logic [TOTAL_BITS-1:0] divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TOTAL_BITS-1:0] out_rem,
	output logic [DVD_BITS-1:0]   out_dvd
);

	logic                  valid_sd;
	logic [TOTAL_BITS-1:0] rem_sd;
	logic [DVD_BITS-1:0]   dvd_sd;
	logic [TOTAL_BITS-1:0] rem_nxt;

	// Take a beat whenever this slot is empty or drains downstream
	assign in_ready = !valid_sd || out_ready;

	// Restoring remainder steps, most significant draw bit first
	always_comb begin
		logic [TOTAL_BITS-1:0] r;
		logic [TOTAL_BITS:0]   t;
		r = in_rem;
		t = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			t = {r, in_dvd[DVD_BITS-1-k]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[TOTAL_BITS-1:0];
		end
		rem_nxt = r;
	end

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (in_ready) begin
			valid_sd <= in_valid;
		end
	end

	// Advance remainder and shift out the consumed draw bits
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_sd <= rem_nxt;
			dvd_sd <= in_dvd << DIV_STEP;
		end
	end

	assign out_valid = valid_sd;
	assign out_rem   = rem_sd;
	assign out_dvd   = dvd_sd;

endmodule

// File: hw/rtl/wrs_select.sv
`timescale 1ns / 1ps

module wrs_select
	import wrs_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int TOTAL_BITS = 17,
	parameter int CNT_BITS   = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TOTAL_BITS-1:0] roll,
	input  logic [TOTAL_BITS-1:0] pre [ENTRIES],
	input  logic [CNT_BITS-1:0]   cnt,
	input  sel_mode_t             mode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [INDEX_BITS-1:0] index
);

	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PICK_W   = IDX_BITS + INDEX_BITS;

	logic                  valid_so;
	logic                  found_so;
	logic [INDEX_BITS-1:0] index_so;
	logic                  found_d;
	logic [INDEX_BITS-1:0] index_d;

	assign in_ready = !valid_so || out_ready;

	// Find the first entry whose running sum exceeds the roll
	always_comb begin
		logic [IDX_BITS-1:0] pick;
		logic [PICK_W-1:0]   pick_w;
		pick = IDX_BITS'(cnt - CNT_BITS'(1));
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (roll < pre[i]) begin
				pick = IDX_BITS'(i);
			end
		end
		pick_w = PICK_W'(pick);
		if (mode.none) begin
			found_d = 1'b0;
			index_d = '0;
		end else if (mode.all_zero) begin
			found_d = 1'b1;
			index_d = '0;
		end else begin
			found_d = 1'b1;
			index_d = pick_w[INDEX_BITS-1:0];
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (in_ready) begin
			valid_so <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			found_so <= found_d;
			index_so <= index_d;
		end
	end

	assign out_valid = valid_so;
	assign found     = found_so;
	assign index     = index_so;

endmodule

// File: hw/rtl/weighted_random_select_top.sv
`timescale 1ns / 1ps

// Channel   Role     Beat / access                 Payload
// s_*       input    s_tvalid & s_tready           tdata[30:0] random_value
// m_*       output   m_tvalid & m_tready           tuser found, tdata[1:0] chosen_index
// apb       config   psel & penable (& pwrite)     weights at 0x0..0xC, count at 0x10
//
// One draw enters per cycle while the output is not stalled; each draw passes
// through an input register, the remainder pipeline retiring DIV_STEP draw bits per
// stage, and the compare stage that also holds the output beat.
// Reset clears the configuration registers and pipeline valids; the table derived
// from the registers is re-registered every cycle. Each stage holds its beat while the
// next one is full, so a stall backs up stage by stage and loses nothing.

module weighted_random_select_top
	import wrs_pkg::*;
#(
	parameter int ENTRIES     = DEF_ENTRIES,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// stream in
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [TDATA_IN_BITS-1:0]  s_tdata,   // [30:0] random_value
	// stream out
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [TDATA_OUT_BITS-1:0] m_tdata,   // [1:0] chosen_index
	output logic                      m_tuser,   // [0] found
	// register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_BITS-1:0]      paddr,
	input  logic [CFG_DATA_BITS-1:0]  pwdata,
	output logic [CFG_DATA_BITS-1:0]  prdata,
	output logic                      pready
);

	localparam int NREG       = (ENTRIES < WEIGHT_REGS) ? ENTRIES : WEIGHT_REGS;
	localparam int CLAMP_BITS = (WEIGHT_BITS > REG_BITS) ? REG_BITS : WEIGHT_BITS - 1;
	localparam int TOTAL_BITS = CLAMP_BITS + $clog2(ENTRIES);
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);

	logic [REG_BITS-1:0]       weight_q [NREG];
	logic [REG_BITS-1:0]       weight_rd [WEIGHT_REGS];
	logic [COUNT_REG_BITS-1:0] count_q;
	logic                      wr_en;
	reg_idx_t                  reg_sel;

	logic [CLAMP_BITS-1:0]     clamp_w [ENTRIES];
	logic [CNT_BITS-1:0]       cnt_sat;
	logic [TOTAL_BITS-1:0]     pre_d [ENTRIES];
	logic [TOTAL_BITS-1:0]     pre_q [ENTRIES];
	logic [CNT_BITS-1:0]       cnt_q;
	sel_mode_t                 mode_d;
	sel_mode_t                 mode_q;

	logic                      valid_s0;
	logic [DVD_BITS-1:0]       rand_s0;

	logic                      v_st   [DIV_STAGES+1];
	logic [TOTAL_BITS-1:0]     rem_st [DIV_STAGES+1];
	logic [DVD_BITS-1:0]       dvd_st [DIV_STAGES+1];
	logic                      rdy_st [DIV_STAGES+1];

	logic                      found;
	logic [INDEX_BITS-1:0]     index;

	// Register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) begin
				weight_q[i] <= '0;
			end
			count_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < NREG; i++) begin
				if (reg_sel == reg_idx_t'(i)) begin
					weight_q[i] <= pwdata[REG_BITS-1:0];
				end
			end
			if (reg_sel == REG_COUNT) begin
				count_q <= pwdata[COUNT_REG_BITS-1:0];
			end
		end
	end

	// Weight slots without a table entry read as zero
	for (genvar g = 0; g < WEIGHT_REGS; g++) begin : g_rd
		if (g < NREG) begin : g_have
			assign weight_rd[g] = weight_q[g];
		end else begin : g_none
			assign weight_rd[g] = '0;
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WEIGHT0: prdata = CFG_DATA_BITS'(weight_rd[0]);
			REG_WEIGHT1: prdata = CFG_DATA_BITS'(weight_rd[1]);
			REG_WEIGHT2: prdata = CFG_DATA_BITS'(weight_rd[2]);
			REG_WEIGHT3: prdata = CFG_DATA_BITS'(weight_rd[3]);
			REG_COUNT:   prdata = CFG_DATA_BITS'(count_q);
			default:     prdata = '0;
		endcase
	end

	// Clamp negative weights to zero; weights wider than a register are taken as unsigned
	for (genvar g = 0; g < ENTRIES; g++) begin : g_clamp
		if (g < NREG) begin : g_reg
			if (WEIGHT_BITS > REG_BITS) begin : g_wide
				assign clamp_w[g] = weight_q[g];
			end else begin : g_signed
				assign clamp_w[g] = weight_q[g][WEIGHT_BITS-1] ? '0 :
					weight_q[g][WEIGHT_BITS-2:0];
			end
		end else begin : g_noreg
			assign clamp_w[g] = '0;
		end
	end

	// Saturate the count, mask unused entries, build running sums
	always_comb begin
		logic [TOTAL_BITS-1:0] acc;
		if (count_q > COUNT_REG_BITS'(ENTRIES)) begin
			cnt_sat = CNT_BITS'(ENTRIES);
		end else begin
			cnt_sat = CNT_BITS'(count_q);
		end
		acc = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (CNT_BITS'(i) < cnt_sat) begin
				acc = acc + TOTAL_BITS'(clamp_w[i]);
			end
			pre_d[i] = acc;
		end
		mode_d.none     = (cnt_sat == '0);
		mode_d.all_zero = (acc == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				pre_q[i] <= '0;
			end
			cnt_q  <= '0;
			mode_q <= '{none: 1'b1, all_zero: 1'b1};
		end else begin
			pre_q  <= pre_d;
			cnt_q  <= cnt_sat;
			mode_q <= mode_d;
		end
	end

	// Input register
	assign s_tready = !valid_s0 || rdy_st[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (s_tready) begin
			valid_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rand_s0 <= DVD_BITS'(s_tdata[RAND_BITS-1:0]);
		end
	end

	assign v_st[0]   = valid_s0;
	assign rem_st[0] = '0;
	assign dvd_st[0] = rand_s0;

	// Remainder pipeline: draw modulo total weight
	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
		wrs_div_stage #(
			.TOTAL_BITS(TOTAL_BITS)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_st[j-1]),
			.in_ready (rdy_st[j-1]),
			.in_rem   (rem_st[j-1]),
			.in_dvd   (dvd_st[j-1]),
			.divisor  (pre_q[ENTRIES-1]),
			.out_valid(v_st[j]),
			.out_ready(rdy_st[j]),
			.out_rem  (rem_st[j]),
			.out_dvd  (dvd_st[j])
		);
	end

	// Compare stage and output register
	wrs_select #(
		.ENTRIES   (ENTRIES),
		.TOTAL_BITS(TOTAL_BITS),
		.CNT_BITS  (CNT_BITS)
	) u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_st[DIV_STAGES]),
		.in_ready (rdy_st[DIV_STAGES]),
		.roll     (rem_st[DIV_STAGES]),
		.pre      (pre_q),
		.cnt      (cnt_q),
		.mode     (mode_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.found    (found),
		.index    (index)
	);

	assign m_tdata = TDATA_OUT_BITS'(index);
	assign m_tuser = found;

endmodule

// File: hw/rtl/wrs_checker.sv
`timescale 1ns / 1ps

module wrs_checker
	import wrs_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [TDATA_OUT_BITS-1:0] m_tdata,
	input logic                      m_tuser
);

	// A stalled output beat holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// No selection always reports index zero
	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("index nonzero without a selection");

	// A draining output lets every stage advance, so input is ready
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while output drains");

	// Nothing is presented while in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind weighted_random_select_top wrs_checker u_chk (.*);
